// File: sv/bsrp_pkg.sv
package bsrp_pkg;

	localparam int KEY_CMP = 18;
	localparam int KEY_COUNT = 20;
	localparam int QDEPTH = 4;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] ALL_ONES = 32'hFFFFFFFF;
	localparam logic [31:0] TOP_BIT = 32'h80000000;

	localparam logic [7:0] TY_SECTION = 8'h00;
	localparam logic [7:0] TY_TEXT = 8'h01;
	localparam logic [7:0] TY_WORD = 8'h02;
	localparam logic [7:0] TY_END = 8'h08;

	localparam logic [2:0] KIND_TEXT = 3'd0;
	localparam logic [2:0] KIND_TEXT_END = 3'd1;
	localparam logic [2:0] KIND_WORD = 3'd2;
	localparam logic [2:0] KIND_ENTRY_END = 3'd3;
	localparam logic [2:0] KIND_FINISHED = 3'd4;

	localparam logic [3:0] CODE_NAME = 4'd0;
	localparam logic [3:0] CODE_EXE = 4'd1;
	localparam logic [3:0] CODE_OPTIONS = 4'd5;
	localparam logic [3:0] CODE_TAG = 4'd6;
	localparam logic [3:0] CODE_HIDDEN = 4'd7;
	localparam logic [3:0] CODE_OVERLAY = 4'd9;
	localparam logic [3:0] CODE_LASTPLAY = 4'd10;
	localparam logic [3:0] CODE_APPID = 4'd11;
	localparam logic [3:0] CODE_NONE = 4'd15;

	localparam int NAME_DEPTH_DEF = 256;
	localparam int KEY_DEPTH_DEF = 24;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_data;
	} in_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  field_code;
		logic [7:0]  value_byte;
		logic [31:0] value_word;
		logic        entry_kept;
		logic        name_truncated;
		logic        last_result;
	} out_t;

	typedef struct packed {
		logic walk;
		out_t res;
	} cmd_t;

	typedef enum logic [12:0] {
		PH_ROOT_TYPE  = 13'b0000000000001,
		PH_ROOT_KEY   = 13'b0000000000010,
		PH_ENTRY_TYPE = 13'b0000000000100,
		PH_ENTRY_KEY  = 13'b0000000001000,
		PH_FIELD_TYPE = 13'b0000000010000,
		PH_FIELD_KEY  = 13'b0000000100000,
		PH_TEXT       = 13'b0000001000000,
		PH_WORD       = 13'b0000010000000,
		PH_SUB_TYPE   = 13'b0000100000000,
		PH_SUB_KEY    = 13'b0001000000000,
		PH_SUB_TEXT   = 13'b0010000000000,
		PH_SUB_WORD   = 13'b0100000000000,
		PH_DONE       = 13'b1000000000000
	} phase_t;

	typedef struct packed {
		logic [KEY_CMP*8-1:0] text;
		logic [4:0]           len;
		logic [1:0]           ftype;
		logic [3:0]           code;
	} key_ent_t;

	localparam key_ent_t KEY_TABLE [KEY_COUNT] = '{
		'{"AppName", 5'd7, 2'd1, 4'd0}, '{"appname", 5'd7, 2'd1, 4'd0},
		'{"Exe", 5'd3, 2'd1, 4'd1}, '{"exe", 5'd3, 2'd1, 4'd1},
		'{"StartDir", 5'd8, 2'd1, 4'd2}, '{"startdir", 5'd8, 2'd1, 4'd2},
		'{"icon", 5'd4, 2'd1, 4'd3},
		'{"ShortcutPath", 5'd12, 2'd1, 4'd4}, '{"shortcutpath", 5'd12, 2'd1, 4'd4},
		'{"LaunchOptions", 5'd13, 2'd1, 4'd5}, '{"launchoptions", 5'd13, 2'd1, 4'd5},
		'{"appid", 5'd5, 2'd2, 4'd11},
		'{"IsHidden", 5'd8, 2'd2, 4'd7}, '{"ishidden", 5'd8, 2'd2, 4'd7},
		'{"AllowDesktopConfig", 5'd18, 2'd2, 4'd8},
		'{"allowdesktopconfig", 5'd18, 2'd2, 4'd8},
		'{"AllowOverlay", 5'd12, 2'd2, 4'd9}, '{"allowoverlay", 5'd12, 2'd2, 4'd9},
		'{"LastPlayTime", 5'd12, 2'd2, 4'd10}, '{"lastplaytime", 5'd12, 2'd2, 4'd10}
	};

	localparam logic [KEY_CMP*8-1:0] KEY_ROOT = "shortcuts";
	localparam logic [KEY_CMP*8-1:0] KEY_TAGS = "tags";

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int j = 0; j < 8; j++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
		end
		return c;
	endfunction

	function automatic logic key_is(input logic [KEY_CMP*8-1:0] keys, input logic [7:0] klen,
		input logic [KEY_CMP*8-1:0] text, input logic [4:0] tlen);
		logic ok;
		ok = (klen == {3'd0, tlen});
		for (int i = 0; i < KEY_CMP; i++) begin
			if (i < int'(tlen)) begin
				if (keys[8*i +: 8] != text[8*(int'(tlen)-1-i) +: 8]) begin
					ok = 1'b0;
				end
			end
		end
		return ok;
	endfunction

	function automatic logic [3:0] key_code(input logic [1:0] ftype,
		input logic [KEY_CMP*8-1:0] keys, input logic [7:0] klen);
		logic [3:0] code;
		code = CODE_NONE;
		for (int i = KEY_COUNT - 1; i >= 0; i--) begin
			if (KEY_TABLE[i].ftype == ftype &&
				key_is(keys, klen, KEY_TABLE[i].text, KEY_TABLE[i].len)) begin
				code = KEY_TABLE[i].code;
			end
		end
		return code;
	endfunction

	function automatic cmd_t mk_res(input logic [2:0] kind, input logic [3:0] code,
		input logic [7:0] vb, input logic [31:0] vw, input logic kept, input logic trunc);
		cmd_t c;
		c.walk = 1'b0;
		c.res.kind = kind;
		c.res.field_code = code;
		c.res.value_byte = vb;
		c.res.value_word = vw;
		c.res.entry_kept = kept;
		c.res.name_truncated = trunc;
		c.res.last_result = 1'b0;
		return c;
	endfunction

endpackage

// File: sv/bsrp_queue.sv
module bsrp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bsrp_pkg::cmd_t  push_data,
	input  logic            pop,
	output bsrp_pkg::cmd_t  head,
	output logic            not_empty,
	output logic            room2
);
	import bsrp_pkg::*;

	localparam int PW = $clog2(QDEPTH);
	localparam int CW = $clog2(QDEPTH + 1);

	cmd_t          mem_q [QDEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign head = mem_q[rd_q];
	assign not_empty = (cnt_q != '0);
	assign room2 = (cnt_q <= CW'(QDEPTH - 2));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

endmodule

// File: sv/bsrp_front.sv
module bsrp_front #(
	parameter int NAME_DEPTH = bsrp_pkg::NAME_DEPTH_DEF,
	parameter int KEY_DEPTH = bsrp_pkg::KEY_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  bsrp_pkg::in_t                   in_data,
	output logic                            push,
	output bsrp_pkg::cmd_t                  push_data,
	input  logic                            room2,
	input  logic                            walk_done,
	output logic [$clog2(NAME_DEPTH+1)-1:0] walk_len,
	output logic                            nb_we,
	output logic [$clog2(NAME_DEPTH)-1:0]   nb_addr,
	output logic [7:0]                      nb_data
);
	import bsrp_pkg::*;

	localparam int NAW = $clog2(NAME_DEPTH);
	localparam int NLW = $clog2(NAME_DEPTH + 1);
	localparam int KLW = $clog2(KEY_DEPTH + 2);
	localparam int KAW = $clog2(KEY_DEPTH);

	phase_t         phase_q, v_phase;
	logic [7:0]     key_store_q [KEY_DEPTH];
	logic [KLW-1:0] klen_q, v_klen;
	logic [7:0]     ftype_q, v_ftype;
	logic           tags_q, v_tags;
	logic [1:0]     wcnt_q, v_wcnt;
	logic [31:0]    wacc_q, v_wacc;
	logic [NLW-1:0] nlen_q, v_nlen;
	logic           novf_q, v_novf;
	logic [31:0]    crc_q, v_crc;
	logic [31:0]    id_q, v_id;
	logic [3:0]     pcode_q, v_pcode;
	logic           busy_q, pend_q;
	cmd_t           pend_cmd_q;
	logic [NLW-1:0] walk_len_q;

	logic [KEY_CMP*8-1:0] keys;
	logic [7:0]           klen8;
	logic [7:0]           b;
	logic                 accept, key_we;
	cmd_t                 cmds [2];
	logic [1:0]           n;
	logic                 has_walk;
	logic                 ee_kept, ee_walk;

	always_comb begin
		for (int i = 0; i < KEY_CMP; i++) begin
			keys[8*i +: 8] = key_store_q[i];
		end
	end

	assign klen8 = 8'(klen_q);
	assign b = in_data.data_byte;
	assign in_stall = pend_q | busy_q | ~room2;
	assign accept = in_valid & ~in_stall;
	assign walk_len = walk_len_q;

	always_comb begin
		v_phase = phase_q; v_klen = klen_q; v_ftype = ftype_q; v_tags = tags_q;
		v_wcnt = wcnt_q; v_wacc = wacc_q; v_nlen = nlen_q; v_novf = novf_q;
		v_crc = crc_q; v_id = id_q; v_pcode = pcode_q;
		key_we = 1'b0; nb_we = 1'b0; n = 2'd0; has_walk = 1'b0;
		nb_addr = nlen_q[NAW-1:0]; nb_data = b;
		cmds[0] = '0; cmds[1] = '0;
		ee_kept = 1'b0; ee_walk = 1'b0;
		case (phase_q)
			PH_ROOT_TYPE: begin
				if (b == TY_SECTION) begin
					v_klen = '0; v_phase = PH_ROOT_KEY;
				end else begin
					cmds[n[0]] = mk_res(KIND_FINISHED, 4'd0, 8'd0, 32'd0, 1'b0, 1'b0);
					n = n + 2'd1; v_phase = PH_DONE;
				end
			end
			PH_ROOT_KEY: begin
				if (b != 8'd0) begin
					key_we = 1'b1;
					if (klen_q <= KLW'(KEY_DEPTH)) v_klen = klen_q + 1'b1;
				end else if (key_is(keys, klen8, KEY_ROOT, 5'd9)) begin
					v_phase = PH_ENTRY_TYPE;
				end else begin
					cmds[n[0]] = mk_res(KIND_FINISHED, 4'd0, 8'd0, 32'd0, 1'b0, 1'b0);
					n = n + 2'd1; v_phase = PH_DONE;
				end
			end
			PH_ENTRY_TYPE: begin
				if (b == TY_SECTION) begin
					v_nlen = '0; v_novf = 1'b0; v_crc = ALL_ONES; v_id = '0;
					v_phase = PH_ENTRY_KEY;
				end else begin
					cmds[n[0]] = mk_res(KIND_FINISHED, 4'd0, 8'd0, 32'd0, 1'b0, 1'b0);
					n = n + 2'd1; v_phase = PH_DONE;
				end
			end
			PH_ENTRY_KEY: begin
				if (b == 8'd0) v_phase = PH_FIELD_TYPE;
			end
			PH_FIELD_TYPE: begin
				if (b == TY_END) begin
					ee_kept = (nlen_q != '0);
					ee_walk = ee_kept && (id_q == '0);
					cmds[n[0]] = mk_res(KIND_ENTRY_END, 4'd0, 8'd0,
						ee_walk ? crc_q : id_q, ee_kept, novf_q);
					cmds[n[0]].walk = ee_walk;
					has_walk = ee_walk;
					n = n + 2'd1; v_phase = PH_ENTRY_TYPE;
				end else begin
					v_ftype = b; v_klen = '0; v_phase = PH_FIELD_KEY;
				end
			end
			PH_FIELD_KEY: begin
				if (b != 8'd0) begin
					key_we = 1'b1;
					if (klen_q <= KLW'(KEY_DEPTH)) v_klen = klen_q + 1'b1;
				end else if (ftype_q == TY_TEXT) begin
					v_pcode = key_code(2'd1, keys, klen8);
					if (v_pcode == CODE_NAME) begin
						v_nlen = '0; v_novf = 1'b0;
					end
					if (v_pcode == CODE_EXE) v_crc = ALL_ONES;
					v_phase = PH_TEXT;
				end else if (ftype_q == TY_WORD) begin
					v_pcode = key_code(2'd2, keys, klen8);
					v_wcnt = '0; v_wacc = '0; v_phase = PH_WORD;
				end else if (ftype_q == TY_SECTION) begin
					v_tags = key_is(keys, klen8, KEY_TAGS, 5'd4);
					v_phase = PH_SUB_TYPE;
				end else begin
					v_phase = PH_FIELD_TYPE;
				end
			end
			PH_TEXT: begin
				if (b != 8'd0) begin
					if (pcode_q <= CODE_OPTIONS) begin
						cmds[n[0]] = mk_res(KIND_TEXT, pcode_q, b, 32'd0, 1'b0, 1'b0);
						n = n + 2'd1;
					end
					if (pcode_q == CODE_NAME) begin
						if (nlen_q < NLW'(NAME_DEPTH)) begin
							nb_we = 1'b1; v_nlen = nlen_q + 1'b1;
						end else begin
							v_novf = 1'b1;
						end
					end
					if (pcode_q == CODE_EXE) v_crc = crc_byte(crc_q, b);
				end else begin
					if (pcode_q <= CODE_OPTIONS) begin
						cmds[n[0]] = mk_res(KIND_TEXT_END, pcode_q, 8'd0, 32'd0, 1'b0, 1'b0);
						n = n + 2'd1;
					end
					v_phase = PH_FIELD_TYPE;
				end
			end
			PH_WORD: begin
				v_wacc = wacc_q | ({24'd0, b} << {wcnt_q, 3'b000});
				if (wcnt_q == 2'd3) begin
					v_wcnt = '0;
					if (pcode_q == CODE_APPID) begin
						v_id = v_wacc;
					end else if (pcode_q >= CODE_HIDDEN && pcode_q <= CODE_OVERLAY) begin
						cmds[n[0]] = mk_res(KIND_WORD, pcode_q, 8'd0,
							{31'd0, v_wacc != 32'd0}, 1'b0, 1'b0);
						n = n + 2'd1;
					end else if (pcode_q == CODE_LASTPLAY) begin
						cmds[n[0]] = mk_res(KIND_WORD, pcode_q, 8'd0, v_wacc, 1'b0, 1'b0);
						n = n + 2'd1;
					end
					v_phase = PH_FIELD_TYPE;
				end else begin
					v_wcnt = wcnt_q + 2'd1;
				end
			end
			PH_SUB_TYPE: begin
				if (b == TY_END) begin
					v_phase = PH_FIELD_TYPE;
				end else begin
					v_ftype = b; v_phase = PH_SUB_KEY;
				end
			end
			PH_SUB_KEY: begin
				if (b == 8'd0) begin
					if (ftype_q == TY_TEXT) begin
						v_phase = PH_SUB_TEXT;
					end else if (ftype_q == TY_WORD) begin
						v_wcnt = '0; v_phase = PH_SUB_WORD;
					end else begin
						v_phase = PH_SUB_TYPE;
					end
				end
			end
			PH_SUB_TEXT: begin
				if (b != 8'd0) begin
					if (tags_q) begin
						cmds[n[0]] = mk_res(KIND_TEXT, CODE_TAG, b, 32'd0, 1'b0, 1'b0);
						n = n + 2'd1;
					end
				end else begin
					if (tags_q) begin
						cmds[n[0]] = mk_res(KIND_TEXT_END, CODE_TAG, 8'd0, 32'd0, 1'b0, 1'b0);
						n = n + 2'd1;
					end
					v_phase = PH_SUB_TYPE;
				end
			end
			PH_SUB_WORD: begin
				if (wcnt_q == 2'd3) begin
					v_wcnt = '0; v_phase = PH_SUB_TYPE;
				end else begin
					v_wcnt = wcnt_q + 2'd1;
				end
			end
			PH_DONE: begin
				v_phase = PH_DONE;
			end
			default: begin
				v_phase = PH_DONE;
			end
		endcase

		if (in_data.end_of_data) begin
			if (v_phase != PH_ROOT_TYPE && v_phase != PH_ROOT_KEY &&
				v_phase != PH_ENTRY_TYPE && v_phase != PH_DONE) begin
				ee_kept = (v_nlen != '0);
				ee_walk = ee_kept && (v_id == '0);
				cmds[n[0]] = mk_res(KIND_ENTRY_END, 4'd0, 8'd0,
					ee_walk ? v_crc : v_id, ee_kept, v_novf);
				cmds[n[0]].walk = ee_walk;
				has_walk = has_walk | ee_walk;
				n = n + 2'd1;
			end else if (v_phase != PH_DONE) begin
				cmds[n[0]] = mk_res(KIND_FINISHED, 4'd0, 8'd0, 32'd0, 1'b0, 1'b0);
				n = n + 2'd1;
			end
		end

		if (n == 2'd1) cmds[0].res.last_result = 1'b1;
		if (n == 2'd2) cmds[1].res.last_result = 1'b1;
	end

	assign push = (accept && n != 2'd0) || pend_q;
	assign push_data = pend_q ? pend_cmd_q : cmds[0];

	always_ff @(posedge clk) begin
		if (accept && key_we && klen_q < KLW'(KEY_DEPTH)) begin
			key_store_q[klen_q[KAW-1:0]] <= b;
		end
		if (accept) begin
			pend_cmd_q <= cmds[1];
		end
		if (accept && has_walk) begin
			walk_len_q <= v_nlen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ROOT_TYPE;
			klen_q <= '0; ftype_q <= '0; tags_q <= 1'b0;
			wcnt_q <= '0; wacc_q <= '0; nlen_q <= '0; novf_q <= 1'b0;
			crc_q <= ALL_ONES; id_q <= '0; pcode_q <= CODE_NONE;
			busy_q <= 1'b0; pend_q <= 1'b0;
		end else begin
			if (accept) begin
				if (in_data.end_of_data) begin
					phase_q <= PH_ROOT_TYPE;
					klen_q <= '0; ftype_q <= '0; tags_q <= 1'b0;
					wcnt_q <= '0; wacc_q <= '0; nlen_q <= '0; novf_q <= 1'b0;
					crc_q <= ALL_ONES; id_q <= '0; pcode_q <= CODE_NONE;
				end else begin
					phase_q <= v_phase;
					klen_q <= v_klen; ftype_q <= v_ftype; tags_q <= v_tags;
					wcnt_q <= v_wcnt; wacc_q <= v_wacc; nlen_q <= v_nlen; novf_q <= v_novf;
					crc_q <= v_crc; id_q <= v_id; pcode_q <= v_pcode;
				end
				pend_q <= (n == 2'd2);
			end else begin
				pend_q <= 1'b0;
			end
			if (accept && has_walk) begin
				busy_q <= 1'b1;
			end else if (walk_done) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

// File: sv/bsrp_back.sv
module bsrp_back #(
	parameter int NAME_DEPTH = bsrp_pkg::NAME_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bsrp_pkg::cmd_t                  head,
	input  logic                            not_empty,
	output logic                            pop,
	input  logic [$clog2(NAME_DEPTH+1)-1:0] walk_len,
	output logic                            walk_done,
	input  logic                            nb_we,
	input  logic [$clog2(NAME_DEPTH)-1:0]   nb_addr,
	input  logic [7:0]                      nb_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output bsrp_pkg::out_t                  out_data
);
	import bsrp_pkg::*;

	localparam int NAW = $clog2(NAME_DEPTH);
	localparam int NLW = $clog2(NAME_DEPTH + 1);

	typedef enum logic [3:0] {
		BK_IDLE = 4'b0001,
		BK_READ = 4'b0010,
		BK_UPD  = 4'b0100,
		BK_FIN  = 4'b1000
	} bk_state_t;

	logic [7:0]     name_mem [NAME_DEPTH];
	bk_state_t      state_q;
	logic [NAW-1:0] idx_q;
	logic [7:0]     rdata_q;
	logic [31:0]    crc_q;
	out_t           meta_q;
	logic           out_valid_q;
	out_t           out_q;
	logic           out_free;
	out_t           walk_res;

	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign out_free = ~out_valid_q | ~out_stall;
	assign pop = (state_q == BK_IDLE) && not_empty && out_free;
	assign walk_done = (state_q == BK_FIN) && out_free;

	always_comb begin
		walk_res = meta_q;
		walk_res.value_word = (crc_q ^ ALL_ONES) | TOP_BIT;
	end

	always_ff @(posedge clk) begin
		if (nb_we) begin
			name_mem[nb_addr] <= nb_data;
		end
		if (state_q == BK_READ) begin
			rdata_q <= name_mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			meta_q <= head.res;
			crc_q <= head.res.value_word;
		end else if (state_q == BK_UPD) begin
			crc_q <= crc_byte(crc_q, rdata_q);
		end
		if (pop && !head.walk) begin
			out_q <= head.res;
		end else if (walk_done) begin
			out_q <= walk_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((pop && !head.walk) || walk_done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				BK_IDLE: begin
					if (pop && head.walk) begin
						idx_q <= '0;
						state_q <= BK_READ;
					end
				end
				BK_READ: begin
					state_q <= BK_UPD;
				end
				BK_UPD: begin
					if (NLW'(idx_q) + 1'b1 == walk_len) begin
						state_q <= BK_FIN;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= BK_READ;
					end
				end
				BK_FIN: begin
					if (out_free) state_q <= BK_IDLE;
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase
		end
	end

endmodule

// File: sv/binary_shortcut_record_parser_core.sv
// Parses a binary key/value shortcut file given one byte per word and streams out text bytes,
// text ends, word fields, entry ends and a finished marker. A byte is normally taken every
// cycle; a byte that causes two results holds the input while its second result is pushed, and
// the input also stalls while the result queue has fewer than two free places. When an entry
// ends with a nonempty name and a zero stored app id, the id is generated by a CRC walk over
// the name memory that reads and then folds in each stored name byte in turn, and no further
// byte is taken until that entry-end result has been handed to the output register.
module binary_shortcut_record_parser_core #(
	parameter int NAME_DEPTH = bsrp_pkg::NAME_DEPTH_DEF,
	parameter int KEY_DEPTH = bsrp_pkg::KEY_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  bsrp_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output bsrp_pkg::out_t out_data
);
	import bsrp_pkg::*;

	localparam int NAW = $clog2(NAME_DEPTH);
	localparam int NLW = $clog2(NAME_DEPTH + 1);

	logic           push, pop, not_empty, room2, walk_done, nb_we;
	cmd_t           push_data, head;
	logic [NLW-1:0] walk_len;
	logic [NAW-1:0] nb_addr;
	logic [7:0]     nb_data;

	bsrp_front #(
		.NAME_DEPTH(NAME_DEPTH),
		.KEY_DEPTH(KEY_DEPTH)
	) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.push(push), .push_data(push_data), .room2(room2),
		.walk_done(walk_done), .walk_len(walk_len),
		.nb_we(nb_we), .nb_addr(nb_addr), .nb_data(nb_data)
	);

	bsrp_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_data(push_data), .pop(pop),
		.head(head), .not_empty(not_empty), .room2(room2)
	);

	bsrp_back #(
		.NAME_DEPTH(NAME_DEPTH)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.head(head), .not_empty(not_empty), .pop(pop),
		.walk_len(walk_len), .walk_done(walk_done),
		.nb_we(nb_we), .nb_addr(nb_addr), .nb_data(nb_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

endmodule

// File: test/binary_shortcut_record_parser_core_test.sv
module binary_shortcut_record_parser_core_test;
	import bsrp_pkg::*;

	localparam int NDEPTH = 256;
	localparam int KDEPTH = 24;
	localparam int CYCLE_LIMIT = 900000;

	typedef enum int {
		ST_ROOT_TYPE, ST_ROOT_KEY, ST_ENTRY_TYPE, ST_ENTRY_KEY, ST_FIELD_TYPE,
		ST_FIELD_KEY, ST_TEXT, ST_WORD, ST_SUB_TYPE, ST_SUB_KEY, ST_SUB_TEXT,
		ST_SUB_WORD, ST_DONE
	} pstate_t;

	typedef struct {
		logic [7:0] data_byte;
		logic       end_of_data;
		logic       has_expect;
		out_t       expect_res;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_t in_data;
	logic out_valid;
	logic out_stall;
	out_t out_data;

	binary_shortcut_record_parser_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	pstate_t ph;
	logic [7:0] keybuf [KDEPTH];
	int keylen;
	logic [7:0] ftype;
	logic tags_on;
	int wcount;
	logic [31:0] wacc;
	logic [7:0] namebuf [NDEPTH];
	int namelen;
	logic nameovf;
	logic [31:0] exesum;
	logic [31:0] appid_held;
	logic [3:0] curcode;

	out_t result_queue[$];
	int mismatches;
	int cycles;
	int send_idle_pct;
	int recv_idle_pct;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cycles <= cycles + 1;

	function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
		c = c ^ {24'd0, b};
		for (int j = 0; j < 8; j++) c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
		return c;
	endfunction

	function automatic logic key_eq(string s);
		if (s.len() > KDEPTH || keylen != s.len()) return 1'b0;
		for (int i = 0; i < s.len(); i++) if (keybuf[i] != s[i]) return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [3:0] lookup_code(logic [7:0] t);
		if (t == TY_TEXT) begin
			if (key_eq("AppName") || key_eq("appname")) return CODE_NAME;
			if (key_eq("Exe") || key_eq("exe")) return CODE_EXE;
			if (key_eq("StartDir") || key_eq("startdir")) return 4'd2;
			if (key_eq("icon")) return 4'd3;
			if (key_eq("ShortcutPath") || key_eq("shortcutpath")) return 4'd4;
			if (key_eq("LaunchOptions") || key_eq("launchoptions")) return CODE_OPTIONS;
		end else if (t == TY_WORD) begin
			if (key_eq("appid")) return CODE_APPID;
			if (key_eq("IsHidden") || key_eq("ishidden")) return CODE_HIDDEN;
			if (key_eq("AllowDesktopConfig") || key_eq("allowdesktopconfig")) return 4'd8;
			if (key_eq("AllowOverlay") || key_eq("allowoverlay")) return CODE_OVERLAY;
			if (key_eq("LastPlayTime") || key_eq("lastplaytime")) return CODE_LASTPLAY;
		end
		return CODE_NONE;
	endfunction

	function automatic out_t make_result(logic [2:0] k, logic [3:0] c, logic [7:0] vb,
		logic [31:0] vw, logic kept, logic trunc);
		out_t r;
		r.kind = k;
		r.field_code = c;
		r.value_byte = vb;
		r.value_word = vw;
		r.entry_kept = kept;
		r.name_truncated = trunc;
		r.last_result = 1'b0;
		return r;
	endfunction

	task automatic parser_clear();
		ph = ST_ROOT_TYPE;
		keylen = 0;
		ftype = 8'd0;
		tags_on = 1'b0;
		wcount = 0;
		wacc = 32'd0;
		namelen = 0;
		nameovf = 1'b0;
		exesum = ALL_ONES;
		appid_held = 32'd0;
		curcode = CODE_NONE;
	endtask

	task automatic push_key(logic [7:0] b);
		if (keylen < KDEPTH) keybuf[keylen] = b;
		if (keylen <= KDEPTH) keylen++;
	endtask

	function automatic out_t entry_close();
		logic [31:0] id;
		logic [31:0] c;
		id = appid_held;
		if (namelen > 0 && id == 32'd0) begin
			c = exesum;
			for (int i = 0; i < namelen && i < NDEPTH; i++) c = crc_step(c, namebuf[i]);
			id = (c ^ ALL_ONES) | TOP_BIT;
		end
		return make_result(KIND_ENTRY_END, 4'd0, 8'd0, id, namelen > 0, nameovf);
	endfunction

	function automatic out_t finished_result();
		return make_result(KIND_FINISHED, 4'd0, 8'd0, 32'd0, 1'b0, 1'b0);
	endfunction

	task automatic predict_byte(logic [7:0] b, logic eod);
		out_t r[$];
		case (ph)
			ST_ROOT_TYPE: begin
				if (b == TY_SECTION) begin
					keylen = 0;
					ph = ST_ROOT_KEY;
				end else begin
					r.insert(r.size(), finished_result());
					ph = ST_DONE;
				end
			end
			ST_ROOT_KEY: begin
				if (b != 8'd0) push_key(b);
				else if (key_eq("shortcuts")) ph = ST_ENTRY_TYPE;
				else begin
					r.insert(r.size(), finished_result());
					ph = ST_DONE;
				end
			end
			ST_ENTRY_TYPE: begin
				if (b == TY_SECTION) begin
					namelen = 0;
					nameovf = 1'b0;
					exesum = ALL_ONES;
					appid_held = 32'd0;
					ph = ST_ENTRY_KEY;
				end else begin
					r.insert(r.size(), finished_result());
					ph = ST_DONE;
				end
			end
			ST_ENTRY_KEY: if (b == 8'd0) ph = ST_FIELD_TYPE;
			ST_FIELD_TYPE: begin
				if (b == TY_END) begin
					r.insert(r.size(), entry_close());
					ph = ST_ENTRY_TYPE;
				end else begin
					ftype = b;
					keylen = 0;
					ph = ST_FIELD_KEY;
				end
			end
			ST_FIELD_KEY: begin
				if (b != 8'd0) push_key(b);
				else if (ftype == TY_TEXT) begin
					curcode = lookup_code(TY_TEXT);
					if (curcode == CODE_NAME) begin
						namelen = 0;
						nameovf = 1'b0;
					end
					if (curcode == CODE_EXE) exesum = ALL_ONES;
					ph = ST_TEXT;
				end else if (ftype == TY_WORD) begin
					curcode = lookup_code(TY_WORD);
					wcount = 0;
					wacc = 32'd0;
					ph = ST_WORD;
				end else if (ftype == TY_SECTION) begin
					tags_on = key_eq("tags");
					ph = ST_SUB_TYPE;
				end else ph = ST_FIELD_TYPE;
			end
			ST_TEXT: begin
				if (b != 8'd0) begin
					if (curcode <= CODE_OPTIONS)
						r.insert(r.size(),
							make_result(KIND_TEXT, curcode, b, 32'd0, 1'b0, 1'b0));
					if (curcode == CODE_NAME) begin
						if (namelen < NDEPTH) namebuf[namelen++] = b;
						else nameovf = 1'b1;
					end
					if (curcode == CODE_EXE) exesum = crc_step(exesum, b);
				end else begin
					if (curcode <= CODE_OPTIONS)
						r.insert(r.size(),
							make_result(KIND_TEXT_END, curcode, 8'd0, 32'd0, 1'b0, 1'b0));
					ph = ST_FIELD_TYPE;
				end
			end
			ST_WORD: begin
				wacc = wacc | ({24'd0, b} << (8 * wcount));
				if (wcount >= 3) begin
					wcount = 0;
					if (curcode == CODE_APPID) appid_held = wacc;
					else if (curcode >= CODE_HIDDEN && curcode <= CODE_OVERLAY)
						r.insert(r.size(), make_result(KIND_WORD, curcode, 8'd0,
							{31'd0, wacc != 32'd0}, 1'b0, 1'b0));
					else if (curcode == CODE_LASTPLAY)
						r.insert(r.size(),
							make_result(KIND_WORD, curcode, 8'd0, wacc, 1'b0, 1'b0));
					ph = ST_FIELD_TYPE;
				end else wcount++;
			end
			ST_SUB_TYPE: begin
				if (b == TY_END) ph = ST_FIELD_TYPE;
				else begin
					ftype = b;
					ph = ST_SUB_KEY;
				end
			end
			ST_SUB_KEY: begin
				if (b == 8'd0) begin
					if (ftype == TY_TEXT) ph = ST_SUB_TEXT;
					else if (ftype == TY_WORD) begin
						wcount = 0;
						ph = ST_SUB_WORD;
					end else ph = ST_SUB_TYPE;
				end
			end
			ST_SUB_TEXT: begin
				if (b != 8'd0) begin
					if (tags_on)
						r.insert(r.size(),
							make_result(KIND_TEXT, CODE_TAG, b, 32'd0, 1'b0, 1'b0));
				end else begin
					if (tags_on)
						r.insert(r.size(),
							make_result(KIND_TEXT_END, CODE_TAG, 8'd0, 32'd0, 1'b0, 1'b0));
					ph = ST_SUB_TYPE;
				end
			end
			ST_SUB_WORD: begin
				if (wcount >= 3) begin
					wcount = 0;
					ph = ST_SUB_TYPE;
				end else wcount++;
			end
			default: ph = ST_DONE;
		endcase
		if (eod) begin
			if (ph >= ST_ENTRY_KEY && ph <= ST_SUB_WORD) r.insert(r.size(), entry_close());
			else if (ph != ST_DONE) r.insert(r.size(), finished_result());
			parser_clear();
		end
		if (r.size() > 0) r[r.size() - 1].last_result = 1'b1;
		foreach (r[i]) result_queue.insert(result_queue.size(), r[i]);
	endtask

	task automatic send_byte(logic [7:0] b, logic eod);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{data_byte: b, end_of_data: eod};
		@(negedge clk);
		while (in_stall) @(negedge clk);
		@(posedge clk);
		predict_byte(b, eod);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
		send_byte(8'd0, 1'b0);
	endtask

	task automatic send_word(logic [31:0] w);
		for (int i = 0; i < 4; i++) send_byte(w[8*i +: 8], 1'b0);
	endtask

	task automatic send_header();
		send_byte(TY_SECTION, 1'b0);
		send_text("shortcuts");
	endtask

	function automatic string pick_text_key();
		case ($urandom_range(13))
			0: return "AppName";
			1: return "appname";
			2: return "Exe";
			3: return "exe";
			4: return "StartDir";
			5: return "startdir";
			6: return "icon";
			7: return "ShortcutPath";
			8: return "shortcutpath";
			9: return "LaunchOptions";
			10: return "launchoptions";
			11: return "appName";
			12: return "comment";
			default: return "ExeX";
		endcase
	endfunction

	function automatic string pick_word_key();
		case ($urandom_range(12))
			0: return "appid";
			1: return "IsHidden";
			2: return "ishidden";
			3: return "AllowDesktopConfig";
			4: return "allowdesktopconfig";
			5: return "AllowOverlay";
			6: return "allowoverlay";
			7: return "LastPlayTime";
			8: return "lastplaytime";
			9: return "AppId";
			10: return "allowdesktopconfigurationlonger";
			11: return "appid";
			default: return "openvr";
		endcase
	endfunction

	task automatic send_rand_text(int maxlen);
		int n;
		n = $urandom_range(maxlen);
		for (int i = 0; i < n; i++) send_byte(8'($urandom_range(1, 255)), 1'b0);
		send_byte(8'd0, 1'b0);
	endtask

	task automatic send_entry();
		int nf;
		nf = $urandom_range(1, 5);
		send_byte(TY_SECTION, 1'b0);
		send_text($sformatf("%0d", $urandom_range(99)));
		for (int f = 0; f < nf; f++) begin
			case ($urandom_range(9))
				0, 1, 2, 3: begin
					send_byte(TY_TEXT, 1'b0);
					send_text(pick_text_key());
					send_rand_text(($urandom_range(7) == 0) ? 12 : 4);
				end
				4, 5, 6: begin
					send_byte(TY_WORD, 1'b0);
					send_text(pick_word_key());
					send_word($urandom_range(1) ? $urandom : $urandom_range(1));
				end
				7, 8: begin
					send_byte(TY_SECTION, 1'b0);
					send_text($urandom_range(3) ? "tags" : "misc");
					repeat ($urandom_range(2)) begin
						case ($urandom_range(2))
							0: begin
								send_byte(TY_TEXT, 1'b0);
								send_text("0");
								send_rand_text(4);
							end
							1: begin
								send_byte(TY_WORD, 1'b0);
								send_text("w");
								send_word($urandom);
							end
							default: begin
								send_byte(8'($urandom_range(3, 7)), 1'b0);
								send_text("x");
							end
						endcase
					end
					send_byte(TY_END, 1'b0);
				end
				default: begin
					send_byte(8'($urandom_range(9, 255)), 1'b0);
					send_text("k");
				end
			endcase
		end
		send_byte(TY_END, 1'b0);
	endtask

	task automatic send_file(int entries);
		if ($urandom_range(15) == 0) begin
			send_byte($urandom_range(1) ? TY_SECTION : 8'($urandom_range(1, 255)), 1'b0);
			send_text($urandom_range(1) ? "shortcutz" : "shortcuts");
		end else send_header();
		for (int i = 0; i < entries; i++) send_entry();
		if ($urandom_range(3) == 0) send_byte(8'($urandom), 1'b1);
		else begin
			send_byte(TY_END, 1'b0);
			send_byte(TY_END, 1'b1);
		end
	endtask

	always @(posedge clk) begin
		out_t got;
		out_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = out_data;
			if (result_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected word %p", got);
			end else begin
				want = result_queue.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) $display("Mismatch: expected %p, actual %p", want, got);
				end
			end
		end
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if (cycles >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		stim_row_t rows[7];
		out_t fin;
		cycles = 0;
		mismatches = 0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 1'b0;
		parser_clear();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		fin = finished_result();
		fin.last_result = 1'b1;
		rows = '{
			'{8'hFF, 1'b0, 1'b1, fin},
			'{8'h00, 1'b0, 1'b0, fin},
			'{8'h00, 1'b1, 1'b0, fin},
			'{8'h00, 1'b0, 1'b0, fin},
			'{8'h78, 1'b0, 1'b0, fin},
			'{8'h00, 1'b0, 1'b1, fin},
			'{8'h01, 1'b1, 1'b0, fin}
		};
		foreach (rows[i]) begin
			send_byte(rows[i].data_byte, rows[i].end_of_data);
			if (rows[i].has_expect && result_queue.size() > 0) begin
				result_queue[result_queue.size() - 1] = rows[i].expect_res;
			end
		end

		send_header();
		send_byte(TY_SECTION, 1'b0);
		send_text("0");
		send_byte(TY_TEXT, 1'b0);
		send_text("Exe");
		send_text("a");
		send_byte(TY_TEXT, 1'b0);
		send_text("AppName");
		for (int i = 0; i < 258; i++) send_byte(8'hFF, 1'b0);
		send_byte(8'd0, 1'b0);
		send_byte(TY_WORD, 1'b0);
		send_text("IsHidden");
		send_word(32'h8000_0000);
		send_byte(TY_WORD, 1'b0);
		send_text("lastplaytime");
		send_word(32'hFFFF_FFFF);
		send_byte(TY_END, 1'b0);
		send_byte(TY_SECTION, 1'b0);
		send_text("1");
		send_byte(TY_WORD, 1'b0);
		send_text("appid");
		send_word(32'h1234_5678);
		send_byte(TY_TEXT, 1'b0);
		send_text("appname");
		send_text("x");
		send_byte(TY_END, 1'b0);
		send_byte(TY_SECTION, 1'b0);
		send_text("2");
		send_byte(TY_TEXT, 1'b0);
		send_text("appname");
		send_byte(8'h41, 1'b1);

		for (int p = 0; p < 3; p++) begin
			send_idle_pct = (p == 0) ? 34 : (p == 1) ? 88 : 0;
			recv_idle_pct = (p == 0) ? 88 : (p == 1) ? 34 : 0;
			send_file($urandom_range(1, 4));
		end
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (3) send_file($urandom_range(0, 3));
		in_valid <= 1'b0;

		while (result_queue.size() > 0) @(posedge clk);
		repeat (600) @(posedge clk);
		if (mismatches == 0 && result_queue.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
